/* rtl/sprite_animation_sequencer_assert.svh */
// ----------------------------------------------------------------------------
// sprite animation sequencer assertion macros
// shared concurrent check forms, clocked on clk with reset arst_n
// ----------------------------------------------------------------------------
`ifndef SPRITE_ANIMATION_SEQUENCER_ASSERT_SVH
`define SPRITE_ANIMATION_SEQUENCER_ASSERT_SVH

// consequent holds in the same cycle
`define SAS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sprite sequencer check failed");

// consequent holds in the next cycle
`define SAS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sprite sequencer check failed");

`endif

/* rtl/sas_pkg.sv */
// ----------------------------------------------------------------------------
// sas_pkg
// command and status codes, table entry and result types
// ----------------------------------------------------------------------------
package sas_pkg;

	typedef enum logic [2:0] {
		CMD_TICK          = 3'd0,
		CMD_SET_ANIM      = 3'd1,
		CMD_SET_ANIM_ONCE = 3'd2,
		CMD_SET_FRAME     = 3'd3,
		CMD_LIST_WRITE    = 3'd4,
		CMD_RECORD_WRITE  = 3'd5,
		CMD_HEADER_WRITE  = 3'd6,
		CMD_SET_POSITION  = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_STARTED  = 3'd0,
		ST_PLAYING  = 3'd1,
		ST_ADVANCED = 3'd2,
		ST_LOOPED   = 3'd3,
		ST_LOCKED   = 3'd4
	} status_t;

	typedef struct packed {
		logic [15:0]        dur;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic [31:0]        flags;
	} rec_t;

	typedef struct packed {
		logic [6:0] len;
		logic       loop;
	} hdr_t;

	typedef struct packed {
		logic [31:0]        flags;
		status_t            status;
		logic [5:0]         frame;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} res_t;

	localparam int REC_W = $bits(rec_t);
	localparam int HDR_W = $bits(hdr_t);

endpackage

/* rtl/sas_ram.sv */
// ----------------------------------------------------------------------------
// sas_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/sas_out_buf.sv */
// ----------------------------------------------------------------------------
// sas_out_buf
// two-entry result queue between the core and the output channel
// ----------------------------------------------------------------------------
module sas_out_buf import sas_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t res,
	input  logic pop,
	output logic valid,
	output logic space,
	output res_t head
);

	res_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign valid = (cnt_q != 2'd0);
	assign space = (cnt_q != 2'd2);
	assign head  = slot_q[rd_q];

endmodule

/* rtl/sas_core.sv */
// ----------------------------------------------------------------------------
// sas_core
// command decode, player state and tick sequencer around the table rams
// ----------------------------------------------------------------------------
`include "sprite_animation_sequencer_assert.svh"

module sas_core import sas_pkg::*; #(
	parameter int ANIM_COUNT      = 16,
	parameter int FRAMES_PER_ANIM = 64,
	parameter int RECORD_COUNT    = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [2:0]         cmd,
	input  logic [15:0]        elapsed,
	input  logic               move_enable,
	input  logic [3:0]         anim_sel,
	input  logic [5:0]         frame_sel,
	input  logic [7:0]         record_id,
	input  logic [15:0]        duration_in,
	input  logic [31:0]        flags_in,
	input  logic signed [15:0] delta_x,
	input  logic signed [15:0] delta_y,
	input  logic [6:0]         length_in,
	input  logic               looped_in,
	output logic               busy,
	output logic               res_push,
	output res_t               res
);

	localparam int LIST_DEPTH = ANIM_COUNT * FRAMES_PER_ANIM;
	localparam int LAW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int HAW = (ANIM_COUNT > 1) ? $clog2(ANIM_COUNT) : 1;
	localparam int RAW = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1;

	typedef enum logic [1:0] {
		T_IDLE,
		T_LOOK,
		T_EVAL,
		T_FLAGS
	} tstate_t;

	function automatic logic [LAW-1:0] list_addr(input logic [3:0] a, input logic [5:0] f);
		return LAW'(32'(a) * FRAMES_PER_ANIM + 32'(f));
	endfunction

	function automatic logic anim_ok(input logic [3:0] a);
		return 32'(a) < ANIM_COUNT;
	endfunction

	function automatic logic frame_ok(input logic [5:0] f);
		return 32'(f) < FRAMES_PER_ANIM;
	endfunction

	function automatic logic rid_ok(input logic [7:0] r);
		return 32'(r) < RECORD_COUNT;
	endfunction

	// player state
	tstate_t            tstate_q, tstate_d;
	logic [3:0]         anim_q, anim_d;
	logic [5:0]         frame_q, frame_d;
	status_t            status_q, status_d;
	logic [31:0]        acc_q, acc_d;
	logic signed [31:0] pos_x_q, pos_x_d;
	logic signed [31:0] pos_y_q, pos_y_d;

	// tick sequencer registers
	logic [31:0] sum_q, sum_d;
	logic        started_q, started_d;
	logic        move_q, move_d;
	logic [5:0]  nframe_q, nframe_d;
	status_t     adv_st_q, adv_st_d;
	logic        list_ok_q, list_ok_d;
	logic        hdr_ok_q, hdr_ok_d;
	logic        rec_ok_q, rec_ok_d;

	// ram ports
	logic             list_we, list_re;
	logic [LAW-1:0]   list_waddr, list_raddr;
	logic [7:0]       list_wdata, list_rdata;
	logic             hdr_we, hdr_re;
	logic [HAW-1:0]   hdr_waddr, hdr_raddr;
	hdr_t             hdr_wdata;
	logic [HDR_W-1:0] hdr_rdata;
	logic             rec_we, rec_re;
	logic [RAW-1:0]   rec_waddr, rec_raddr;
	rec_t             rec_wdata;
	logic [REC_W-1:0] rec_rdata;

	logic [7:0]  rid_look;
	hdr_t        hdr;
	rec_t        rec;
	logic [19:0] thr;
	logic [32:0] acc_sum;
	logic [31:0] sat_sum;
	logic [6:0]  nx;
	logic [6:0]  nfr;
	status_t     nst;
	logic [6:0]  len_clamp;
	logic [31:0] res_flags;

	sas_ram #(.WIDTH(8), .DEPTH(LIST_DEPTH)) u_list_ram (
		.clk   (clk),
		.we    (list_we),
		.waddr (list_waddr),
		.wdata (list_wdata),
		.re    (list_re),
		.raddr (list_raddr),
		.rdata (list_rdata)
	);

	sas_ram #(.WIDTH(HDR_W), .DEPTH(ANIM_COUNT)) u_hdr_ram (
		.clk   (clk),
		.we    (hdr_we),
		.waddr (hdr_waddr),
		.wdata (hdr_wdata),
		.re    (hdr_re),
		.raddr (hdr_raddr),
		.rdata (hdr_rdata)
	);

	sas_ram #(.WIDTH(REC_W), .DEPTH(RECORD_COUNT)) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (rec_wdata),
		.re    (rec_re),
		.raddr (rec_raddr),
		.rdata (rec_rdata)
	);

	always_comb begin
		rid_look = list_ok_q ? list_rdata : 8'd0;
		hdr      = hdr_ok_q ? hdr_t'(hdr_rdata) : '0;
		rec      = rec_ok_q ? rec_t'(rec_rdata) : '0;
		thr      = {rec.dur, 4'b0000};

		// saturating accumulate
		acc_sum = {1'b0, acc_q} + 33'(elapsed);
		sat_sum = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];

		// frame that an advance would enter
		nx = {1'b0, frame_q} + 7'd1;
		if (nx >= hdr.len) begin
			if (hdr.loop) begin
				nfr = 7'd0;
				nst = ST_LOOPED;
			end else begin
				nfr = (hdr.len != 7'd0) ? hdr.len - 7'd1 : 7'd0;
				nst = ST_LOCKED;
			end
		end else begin
			nfr = nx;
			nst = ST_ADVANCED;
		end

		if (length_in == 7'd0) begin
			len_clamp = 7'd1;
		end else if (32'(length_in) > FRAMES_PER_ANIM) begin
			len_clamp = 7'(FRAMES_PER_ANIM);
		end else begin
			len_clamp = length_in;
		end
	end

	always_comb begin
		tstate_d  = tstate_q;
		anim_d    = anim_q;
		frame_d   = frame_q;
		status_d  = status_q;
		acc_d     = acc_q;
		pos_x_d   = pos_x_q;
		pos_y_d   = pos_y_q;
		sum_d     = sum_q;
		started_d = started_q;
		move_d    = move_q;
		nframe_d  = nframe_q;
		adv_st_d  = adv_st_q;
		list_ok_d = list_ok_q;
		hdr_ok_d  = hdr_ok_q;
		rec_ok_d  = rec_ok_q;

		list_we    = 1'b0;
		list_waddr = list_addr(anim_sel, frame_sel);
		list_wdata = record_id;
		list_re    = 1'b0;
		list_raddr = list_addr(anim_q, frame_q);
		hdr_we     = 1'b0;
		hdr_waddr  = HAW'(anim_sel);
		hdr_wdata  = '{len: len_clamp, loop: looped_in};
		hdr_re     = 1'b0;
		hdr_raddr  = HAW'(anim_q);
		rec_we     = 1'b0;
		rec_waddr  = RAW'(record_id);
		rec_wdata  = '{dur: duration_in, dx: delta_x, dy: delta_y, flags: flags_in};
		rec_re     = 1'b0;
		rec_raddr  = RAW'(rid_look);

		res_push  = 1'b0;
		res_flags = 32'd0;

		unique case (tstate_q)
			T_IDLE: begin
				if (take) begin
					unique case (cmd_t'(cmd))
						CMD_TICK: begin
							if (status_q == ST_LOCKED) begin
								res_push = 1'b1;
							end else begin
								list_re   = 1'b1;
								hdr_re    = 1'b1;
								sum_d     = sat_sum;
								started_d = (status_q == ST_STARTED);
								move_d    = move_enable;
								list_ok_d = anim_ok(anim_q) && frame_ok(frame_q);
								hdr_ok_d  = anim_ok(anim_q);
								tstate_d  = T_LOOK;
							end
						end
						CMD_SET_ANIM: begin
							anim_d   = anim_sel;
							frame_d  = frame_sel;
							acc_d    = 32'd0;
							status_d = ST_STARTED;
							res_push = 1'b1;
						end
						CMD_SET_ANIM_ONCE: begin
							if (anim_sel != anim_q) begin
								anim_d   = anim_sel;
								frame_d  = frame_sel;
								acc_d    = 32'd0;
								status_d = ST_STARTED;
							end
							res_push = 1'b1;
						end
						CMD_SET_FRAME: begin
							frame_d  = frame_sel;
							acc_d    = 32'd0;
							status_d = ST_PLAYING;
							res_push = 1'b1;
						end
						CMD_LIST_WRITE: begin
							list_we  = anim_ok(anim_sel) && frame_ok(frame_sel);
							res_push = 1'b1;
						end
						CMD_RECORD_WRITE: begin
							rec_we   = rid_ok(record_id);
							res_push = 1'b1;
						end
						CMD_HEADER_WRITE: begin
							hdr_we   = anim_ok(anim_sel);
							res_push = 1'b1;
						end
						CMD_SET_POSITION: begin
							pos_x_d  = {{16{delta_x[15]}}, delta_x};
							pos_y_d  = {{16{delta_y[15]}}, delta_y};
							res_push = 1'b1;
						end
					endcase
				end
			end
			T_LOOK: begin
				// current record, and list entry of the frame an advance would enter
				rec_re    = 1'b1;
				rec_ok_d  = rid_ok(rid_look);
				nframe_d  = nfr[5:0];
				adv_st_d  = nst;
				list_re   = 1'b1;
				list_raddr = list_addr(anim_q, nfr[5:0]);
				list_ok_d = anim_ok(anim_q) && frame_ok(nfr[5:0]);
				tstate_d  = T_EVAL;
			end
			T_EVAL: begin
				if (sum_q >= 32'(thr)) begin
					acc_d    = sum_q - 32'(thr);
					status_d = adv_st_q;
					frame_d  = nframe_q;
					if (move_q) begin
						pos_x_d = pos_x_q + {{16{rec.dx[15]}}, rec.dx};
						pos_y_d = pos_y_q + {{16{rec.dy[15]}}, rec.dy};
					end
					rec_re   = 1'b1;
					rec_ok_d = rid_ok(rid_look);
					tstate_d = T_FLAGS;
				end else begin
					acc_d     = sum_q;
					status_d  = ST_PLAYING;
					res_flags = started_q ? rec.flags : 32'd0;
					res_push  = 1'b1;
					tstate_d  = T_IDLE;
				end
			end
			T_FLAGS: begin
				res_flags = rec.flags;
				res_push  = 1'b1;
				tstate_d  = T_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tstate_q  <= T_IDLE;
			anim_q    <= 4'd0;
			frame_q   <= 6'd0;
			status_q  <= ST_STARTED;
			acc_q     <= 32'd0;
			pos_x_q   <= 32'sd0;
			pos_y_q   <= 32'sd0;
			sum_q     <= 32'd0;
			started_q <= 1'b0;
			move_q    <= 1'b0;
			nframe_q  <= 6'd0;
			adv_st_q  <= ST_PLAYING;
			list_ok_q <= 1'b0;
			hdr_ok_q  <= 1'b0;
			rec_ok_q  <= 1'b0;
		end else begin
			tstate_q  <= tstate_d;
			anim_q    <= anim_d;
			frame_q   <= frame_d;
			status_q  <= status_d;
			acc_q     <= acc_d;
			pos_x_q   <= pos_x_d;
			pos_y_q   <= pos_y_d;
			sum_q     <= sum_d;
			started_q <= started_d;
			move_q    <= move_d;
			nframe_q  <= nframe_d;
			adv_st_q  <= adv_st_d;
			list_ok_q <= list_ok_d;
			hdr_ok_q  <= hdr_ok_d;
			rec_ok_q  <= rec_ok_d;
		end
	end

	assign busy = (tstate_q != T_IDLE);
	assign res  = '{flags: res_flags, status: status_d, frame: frame_d,
	                pos_x: pos_x_d, pos_y: pos_y_d};

	`SAS_ASSERT_SAME(a_take_idle, take, tstate_q == T_IDLE)
	`SAS_ASSERT_NEXT(a_look_eval, tstate_q == T_LOOK, tstate_q == T_EVAL)
	`SAS_ASSERT_SAME(a_flags_push, tstate_q == T_FLAGS, res_push)
	`SAS_ASSERT_SAME(a_wr_idle, list_we || hdr_we || rec_we, take && tstate_q == T_IDLE)

endmodule

/* rtl/sprite_animation_sequencer.sv */
// ----------------------------------------------------------------------------
// sprite_animation_sequencer
// table-driven sprite animation player with frame list, header and record rams
//
//   channel | role          | handshake           | fields
//   in      | command items | in_valid, in_stall  | cmd .. looped_in
//   out     | result items  | out_valid, out_stall| frame_flags .. pos_y
//
// table writes, selects and position items push their result when taken
// as does a locked tick; other ticks pass the look and eval states, plus flags
// on an advance, for the chained list+header, record+list, record ram reads
// a two-entry result queue lets items enter while a result waits on out_stall
// reset clears player state only; tables hold no valid state and need no sweep
// ----------------------------------------------------------------------------
module sprite_animation_sequencer import sas_pkg::*; #(
	parameter int ANIM_COUNT      = 16,
	parameter int FRAMES_PER_ANIM = 64,
	parameter int RECORD_COUNT    = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic [15:0]        elapsed,
	input  logic               move_enable,
	input  logic [3:0]         anim_sel,
	input  logic [5:0]         frame_sel,
	input  logic [7:0]         record_id,
	input  logic [15:0]        duration_in,
	input  logic [31:0]        flags_in,
	input  logic signed [15:0] delta_x,
	input  logic signed [15:0] delta_y,
	input  logic [6:0]         length_in,
	input  logic               looped_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        frame_flags,
	output logic [2:0]         play_status,
	output logic [5:0]         frame_now,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y
);

	logic take;
	logic busy;
	logic res_push;
	res_t res;
	logic space;
	res_t head;

	// one item in work at a time, room in the queue for its result
	assign in_stall = busy || !space;
	assign take     = in_valid && !in_stall;

	sas_core #(
		.ANIM_COUNT      (ANIM_COUNT),
		.FRAMES_PER_ANIM (FRAMES_PER_ANIM),
		.RECORD_COUNT    (RECORD_COUNT)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.cmd         (cmd),
		.elapsed     (elapsed),
		.move_enable (move_enable),
		.anim_sel    (anim_sel),
		.frame_sel   (frame_sel),
		.record_id   (record_id),
		.duration_in (duration_in),
		.flags_in    (flags_in),
		.delta_x     (delta_x),
		.delta_y     (delta_y),
		.length_in   (length_in),
		.looped_in   (looped_in),
		.busy        (busy),
		.res_push    (res_push),
		.res         (res)
	);

	sas_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.res    (res),
		.pop    (out_valid && !out_stall),
		.valid  (out_valid),
		.space  (space),
		.head   (head)
	);

	assign frame_flags = head.flags;
	assign play_status = head.status;
	assign frame_now   = head.frame;
	assign pos_x       = head.pos_x;
	assign pos_y       = head.pos_y;

endmodule

/* sim/tb_sprite_animation_sequencer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sprite_animation_sequencer
// self-checking bench for the sprite animation sequencer: a directed opening
// covers the table, select, tick, lock and loop corners, then random command
// streams that keep every tick on written table entries. a local player model
// predicts each result at input transfer time and the monitor compares every
// output transfer field by field, with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module tb_sprite_animation_sequencer import sas_pkg::*;;

	localparam int ANIM_COUNT      = 16;
	localparam int FRAMES_PER_ANIM = 64;
	localparam int RECORD_COUNT    = 256;
	localparam int ITEM_TARGET     = 1400;
	localparam int CYCLE_LIMIT     = 900000;
	localparam int DRAIN_CYCLES    = 10;
	localparam int PLAN            = 0;
	localparam int TRACK           = 1;

	typedef struct {
		cmd_t               cmd;
		logic [15:0]        elapsed;
		logic               move_enable;
		logic [3:0]         anim_sel;
		logic [5:0]         frame_sel;
		logic [7:0]         record_id;
		logic [15:0]        duration_in;
		logic [31:0]        flags_in;
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
		logic [6:0]         length_in;
		logic               looped_in;
	} sprite_item_t;

	typedef enum {NEED_NONE, NEED_LIST, NEED_RECORD, NEED_HEADER} table_need_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         cmd = '0;
	logic [15:0]        elapsed = '0;
	logic               move_enable = 1'b0;
	logic [3:0]         anim_sel = '0;
	logic [5:0]         frame_sel = '0;
	logic [7:0]         record_id = '0;
	logic [15:0]        duration_in = '0;
	logic [31:0]        flags_in = '0;
	logic signed [15:0] delta_x = '0;
	logic signed [15:0] delta_y = '0;
	logic [6:0]         length_in = '0;
	logic               looped_in = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [31:0]        frame_flags;
	logic [2:0]         play_status;
	logic [5:0]         frame_now;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;

	sprite_animation_sequencer uut (.*);

	// two copies of the player: one steers generation, one predicts results
	logic [7:0]         frame_map [2][ANIM_COUNT*FRAMES_PER_ANIM];
	hdr_t               hdr_tab [2][ANIM_COUNT];
	rec_t               rec_tab [2][RECORD_COUNT];
	logic [3:0]         anim_r [2];
	logic [5:0]         frame_r [2];
	status_t            stat_r [2];
	logic [31:0]        acc_r [2];
	logic signed [31:0] pos_x_r [2];
	logic signed [31:0] pos_y_r [2];

	bit list_ok [ANIM_COUNT*FRAMES_PER_ANIM];
	bit rec_ok [RECORD_COUNT];
	bit hdr_ok [ANIM_COUNT];

	sprite_item_t cmd_backlog [$];
	res_t         result_due [$];
	sprite_item_t drv_item;
	bit           in_taken = 1'b0;
	int           planned = 0;
	int           accepted_items = 0;
	int           errors = 0;
	int           cycles = 0;
	int           gap_left = 0;
	int           stall_left = 0;
	int           calm_in = 0;
	int           calm_out = 0;

	function automatic res_t next_player_result(int s, sprite_item_t it);
		res_t        r;
		logic [7:0]  rid;
		rec_t        m;
		hdr_t        h;
		logic [32:0] sum;
		logic [31:0] thr;
		logic [6:0]  nxt;
		r.flags = '0;
		case (it.cmd)
			CMD_TICK: begin
				if (stat_r[s] != ST_LOCKED) begin
					rid = frame_map[s][{anim_r[s], frame_r[s]}];
					m = rec_tab[s][rid];
					if (stat_r[s] == ST_STARTED)
						r.flags = m.flags;
					stat_r[s] = ST_PLAYING;
					sum = {1'b0, acc_r[s]} + {17'd0, it.elapsed};
					acc_r[s] = sum[32] ? '1 : sum[31:0];
					thr = {12'd0, m.dur, 4'd0};
					if (acc_r[s] >= thr) begin
						stat_r[s] = ST_ADVANCED;
						if (it.move_enable) begin
							pos_x_r[s] = pos_x_r[s] + {{16{m.dx[15]}}, m.dx};
							pos_y_r[s] = pos_y_r[s] + {{16{m.dy[15]}}, m.dy};
						end
						acc_r[s] = acc_r[s] - thr;
						nxt = {1'b0, frame_r[s]} + 7'd1;
						h = hdr_tab[s][anim_r[s]];
						if (nxt >= h.len) begin
							if (h.loop) begin
								nxt = '0;
								stat_r[s] = ST_LOOPED;
							end else begin
								nxt = h.len - 7'd1;
								stat_r[s] = ST_LOCKED;
							end
						end
						frame_r[s] = nxt[5:0];
						r.flags = rec_tab[s][frame_map[s][{anim_r[s], frame_r[s]}]].flags;
					end
				end
			end
			CMD_SET_ANIM, CMD_SET_ANIM_ONCE: begin
				if (it.cmd == CMD_SET_ANIM || it.anim_sel != anim_r[s]) begin
					anim_r[s] = it.anim_sel;
					frame_r[s] = it.frame_sel;
					acc_r[s] = '0;
					stat_r[s] = ST_STARTED;
				end
			end
			CMD_SET_FRAME: begin
				frame_r[s] = it.frame_sel;
				acc_r[s] = '0;
				stat_r[s] = ST_PLAYING;
			end
			CMD_LIST_WRITE: frame_map[s][{it.anim_sel, it.frame_sel}] = it.record_id;
			CMD_RECORD_WRITE: begin
				rec_tab[s][it.record_id].dur = it.duration_in;
				rec_tab[s][it.record_id].dx = it.delta_x;
				rec_tab[s][it.record_id].dy = it.delta_y;
				rec_tab[s][it.record_id].flags = it.flags_in;
			end
			CMD_HEADER_WRITE: begin
				if (it.length_in == 7'd0)
					hdr_tab[s][it.anim_sel].len = 7'd1;
				else if (it.length_in > FRAMES_PER_ANIM)
					hdr_tab[s][it.anim_sel].len = 7'(FRAMES_PER_ANIM);
				else
					hdr_tab[s][it.anim_sel].len = it.length_in;
				hdr_tab[s][it.anim_sel].loop = it.looped_in;
			end
			default: begin
				pos_x_r[s] = {{16{it.delta_x[15]}}, it.delta_x};
				pos_y_r[s] = {{16{it.delta_y[15]}}, it.delta_y};
			end
		endcase
		r.status = stat_r[s];
		r.frame = frame_r[s];
		r.pos_x = pos_x_r[s];
		r.pos_y = pos_y_r[s];
		return r;
	endfunction

	// first table entry a tick would read before it has been written
	function automatic table_need_t tick_needs(logic [15:0] el, output int idx);
		logic [9:0]  li;
		logic [7:0]  rid;
		logic [32:0] sum;
		logic [31:0] acc_new;
		logic [6:0]  nxt;
		hdr_t        h;
		idx = 0;
		if (stat_r[PLAN] == ST_LOCKED)
			return NEED_NONE;
		li = {anim_r[PLAN], frame_r[PLAN]};
		if (!list_ok[li]) begin
			idx = li;
			return NEED_LIST;
		end
		rid = frame_map[PLAN][li];
		if (!rec_ok[rid]) begin
			idx = rid;
			return NEED_RECORD;
		end
		sum = {1'b0, acc_r[PLAN]} + {17'd0, el};
		acc_new = sum[32] ? '1 : sum[31:0];
		if (acc_new < {12'd0, rec_tab[PLAN][rid].dur, 4'd0})
			return NEED_NONE;
		if (!hdr_ok[anim_r[PLAN]]) begin
			idx = anim_r[PLAN];
			return NEED_HEADER;
		end
		h = hdr_tab[PLAN][anim_r[PLAN]];
		nxt = {1'b0, frame_r[PLAN]} + 7'd1;
		if (nxt >= h.len)
			nxt = h.loop ? 7'd0 : h.len - 7'd1;
		li = {anim_r[PLAN], nxt[5:0]};
		if (!list_ok[li]) begin
			idx = li;
			return NEED_LIST;
		end
		rid = frame_map[PLAN][li];
		if (!rec_ok[rid]) begin
			idx = rid;
			return NEED_RECORD;
		end
		return NEED_NONE;
	endfunction

	function automatic sprite_item_t random_item(cmd_t c);
		sprite_item_t it;
		it.cmd = c;
		it.elapsed = 16'($urandom());
		it.move_enable = 1'($urandom());
		it.anim_sel = 4'($urandom());
		it.frame_sel = 6'($urandom());
		it.record_id = 8'($urandom());
		it.duration_in = 16'($urandom());
		it.flags_in = $urandom();
		it.delta_x = 16'($urandom());
		it.delta_y = 16'($urandom());
		it.length_in = 7'($urandom());
		it.looped_in = 1'($urandom());
		return it;
	endfunction

	function automatic logic [15:0] pick_duration();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return 16'd0;
		if (r < 75) return 16'($urandom_range(1, 6));
		if (r < 92) return 16'($urandom_range(7, 100));
		return 16'($urandom());
	endfunction

	function automatic logic [15:0] pick_elapsed();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 16'($urandom_range(0, 40));
		if (r < 70) return 16'($urandom_range(0, 200));
		if (r < 90) return 16'($urandom());
		return r[0] ? 16'hffff : 16'h0000;
	endfunction

	function automatic logic [6:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 7'($urandom_range(1, 8));
		if (r < 80) return 7'd0;
		if (r < 90) return 7'($urandom_range(65, 127));
		return 7'($urandom_range(1, 64));
	endfunction

	function automatic logic [7:0] pick_record();
		return ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 15)) : 8'($urandom());
	endfunction

	function automatic logic [3:0] pick_anim();
		return ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom());
	endfunction

	function automatic logic [5:0] pick_frame();
		return ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 3)) : 6'($urandom());
	endfunction

	function automatic int idle_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic plan_item(sprite_item_t it);
		void'(next_player_result(PLAN, it));
		case (it.cmd)
			CMD_LIST_WRITE:   list_ok[{it.anim_sel, it.frame_sel}] = 1'b1;
			CMD_RECORD_WRITE: rec_ok[it.record_id] = 1'b1;
			CMD_HEADER_WRITE: hdr_ok[it.anim_sel] = 1'b1;
			default: ;
		endcase
		cmd_backlog.push_back(it);
		planned++;
	endtask

	// a tick is preceded by writes of any table entry it would read unwritten
	task automatic queue_item(sprite_item_t it);
		sprite_item_t f;
		table_need_t  need;
		int           idx;
		if (it.cmd == CMD_TICK) begin
			need = tick_needs(it.elapsed, idx);
			while (need != NEED_NONE) begin
				case (need)
					NEED_LIST: begin
						f = random_item(CMD_LIST_WRITE);
						f.anim_sel = idx[9:6];
						f.frame_sel = idx[5:0];
						f.record_id = pick_record();
					end
					NEED_RECORD: begin
						f = random_item(CMD_RECORD_WRITE);
						f.record_id = idx[7:0];
						f.duration_in = pick_duration();
					end
					default: begin
						f = random_item(CMD_HEADER_WRITE);
						f.anim_sel = idx[3:0];
						f.length_in = pick_length();
					end
				endcase
				plan_item(f);
				need = tick_needs(it.elapsed, idx);
			end
		end
		plan_item(it);
	endtask

	task automatic put_header(logic [3:0] a, logic [6:0] len, logic lp);
		sprite_item_t it;
		it = random_item(CMD_HEADER_WRITE);
		it.anim_sel = a;
		it.length_in = len;
		it.looped_in = lp;
		queue_item(it);
	endtask

	task automatic put_record(logic [7:0] id, logic [15:0] dur, logic [31:0] fl,
			logic [15:0] dx, logic [15:0] dy);
		sprite_item_t it;
		it = random_item(CMD_RECORD_WRITE);
		it.record_id = id;
		it.duration_in = dur;
		it.flags_in = fl;
		it.delta_x = dx;
		it.delta_y = dy;
		queue_item(it);
	endtask

	task automatic put_list(logic [3:0] a, logic [5:0] f, logic [7:0] id);
		sprite_item_t it;
		it = random_item(CMD_LIST_WRITE);
		it.anim_sel = a;
		it.frame_sel = f;
		it.record_id = id;
		queue_item(it);
	endtask

	task automatic put_tick(logic [15:0] el, logic mv);
		sprite_item_t it;
		it = random_item(CMD_TICK);
		it.elapsed = el;
		it.move_enable = mv;
		queue_item(it);
	endtask

	task automatic put_select(cmd_t c, logic [3:0] a, logic [5:0] f);
		sprite_item_t it;
		it = random_item(c);
		it.anim_sel = a;
		it.frame_sel = f;
		queue_item(it);
	endtask

	task automatic put_position(logic [15:0] x, logic [15:0] y);
		sprite_item_t it;
		it = random_item(CMD_SET_POSITION);
		it.delta_x = x;
		it.delta_y = y;
		queue_item(it);
	endtask

	task automatic build_stimulus();
		int r;
		// directed corners
		put_header(4'd0, 7'd3, 1'b1);
		put_record(8'd0, 16'd0, 32'hffff_ffff, 16'h7fff, 16'h8000);
		put_record(8'd255, 16'hffff, 32'h0000_0000, 16'h8000, 16'h7fff);
		put_record(8'd1, 16'd1, 32'ha5a5_5a5a, 16'hffff, 16'h0001);
		put_list(4'd0, 6'd0, 8'd0);
		put_list(4'd0, 6'd1, 8'd1);
		put_list(4'd0, 6'd2, 8'd255);
		put_position(16'h7fff, 16'h8000);
		put_tick(16'd0, 1'b1);
		put_tick(16'd16, 1'b1);
		put_tick(16'hffff, 1'b0);
		put_position(16'h8000, 16'h7fff);
		put_select(CMD_SET_FRAME, 4'd0, 6'd63);
		put_tick(16'hffff, 1'b1);
		put_header(4'd2, 7'd0, 1'b0);
		put_header(4'd15, 7'd127, 1'b0);
		put_list(4'd2, 6'd0, 8'd0);
		put_select(CMD_SET_ANIM, 4'd2, 6'd0);
		put_tick(16'd5, 1'b1);
		put_tick(16'd5, 1'b1);
		put_select(CMD_SET_ANIM_ONCE, 4'd2, 6'd5);
		put_select(CMD_SET_ANIM_ONCE, 4'd0, 6'd1);
		put_tick(16'd16, 1'b0);
		put_select(CMD_SET_ANIM, 4'd15, 6'd63);
		put_tick(16'hffff, 1'b1);
		// random streams
		while (planned < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				put_tick(pick_elapsed(), 1'($urandom()));
			end else if (r < 55) begin
				put_select(CMD_SET_ANIM, pick_anim(), pick_frame());
			end else if (r < 60) begin
				put_select(CMD_SET_ANIM_ONCE, $urandom_range(0, 1) ? anim_r[PLAN] : pick_anim(),
					pick_frame());
			end else if (r < 65) begin
				put_select(CMD_SET_FRAME, 4'($urandom()), pick_frame());
			end else if (r < 75) begin
				put_list(pick_anim(), pick_frame(), pick_record());
			end else if (r < 85) begin
				put_record(pick_record(), pick_duration(), $urandom(), 16'($urandom()),
					16'($urandom()));
			end else if (r < 90) begin
				put_header(pick_anim(), pick_length(), 1'($urandom()));
			end else begin
				put_position(16'($urandom()), 16'($urandom()));
			end
		end
	endtask

	initial begin
		forever #6 clk = ~clk;
	end

	// input driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_taken) begin
			end else if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (cmd_backlog.size() > 0) begin
				drv_item = cmd_backlog.pop_front();
				cmd <= drv_item.cmd;
				elapsed <= drv_item.elapsed;
				move_enable <= drv_item.move_enable;
				anim_sel <= drv_item.anim_sel;
				frame_sel <= drv_item.frame_sel;
				record_id <= drv_item.record_id;
				duration_in <= drv_item.duration_in;
				flags_in <= drv_item.flags_in;
				delta_x <= drv_item.delta_x;
				delta_y <= drv_item.delta_y;
				length_in <= drv_item.length_in;
				looped_in <= drv_item.looped_in;
				in_valid <= 1'b1;
				gap_left = idle_len(calm_in);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output stall
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			if ($urandom_range(0, 3) == 0)
				stall_left = idle_len(calm_out);
		end
	end

	// predict on input transfer, check on output transfer
	always @(posedge clk) begin
		res_t want;
		in_taken = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				in_taken = 1'b1;
				result_due.push_back(next_player_result(TRACK, drv_item));
				accepted_items++;
			end
			if (out_valid && !out_stall) begin
				if (result_due.size() == 0) begin
					$error("result transfer with no result expected");
					errors++;
				end else begin
					want = result_due.pop_front();
					if (frame_flags !== want.flags) begin
						$error("frame_flags: expected %h actual %h", want.flags, frame_flags);
						errors++;
					end
					if (play_status !== want.status) begin
						$error("play_status: expected %0d actual %0d", want.status, play_status);
						errors++;
					end
					if (frame_now !== want.frame) begin
						$error("frame_now: expected %0d actual %0d", want.frame, frame_now);
						errors++;
					end
					if (pos_x !== want.pos_x) begin
						$error("pos_x: expected %0d actual %0d", want.pos_x, pos_x);
						errors++;
					end
					if (pos_y !== want.pos_y) begin
						$error("pos_y: expected %0d actual %0d", want.pos_y, pos_y);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_sprite_animation_sequencer NOT OK");
			$finish;
		end
	end

	initial begin
		for (int s = 0; s < 2; s++) begin
			anim_r[s] = '0;
			frame_r[s] = '0;
			stat_r[s] = ST_STARTED;
			acc_r[s] = '0;
			pos_x_r[s] = '0;
			pos_y_r[s] = '0;
		end
		build_stimulus();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (accepted_items != planned || result_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && result_due.size() == 0)
			$display("tb_sprite_animation_sequencer OK");
		else
			$display("tb_sprite_animation_sequencer NOT OK");
		$finish;
	end

endmodule

/* sprite_animation_sequencer.f */
+incdir+rtl
rtl/sas_pkg.sv
rtl/sas_ram.sv
rtl/sas_out_buf.sv
rtl/sas_core.sv
rtl/sprite_animation_sequencer.sv
sim/tb_sprite_animation_sequencer.sv
